>>> hdl/pres_pkg.sv
// Shared types, codes and round functions of the PRESENT encryption pipeline.
package pres_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_KEY_SIZE_MODE = 2'd0,
		CFG_KEY_UPPER     = 2'd1,
		CFG_KEY_LOWER     = 2'd2
	} cfg_index_t;

	localparam int unsigned NumRounds = 31;

	// Data and key state that travels down the pipeline with each block.
	typedef struct packed {
		logic [63:0] state;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic        wide;
	} pres_stage_t;

	function automatic logic [3:0] sbox4(input logic [3:0] x);
		logic [3:0] y;
		case (x)
			4'h0: y = 4'hC;
			4'h1: y = 4'h5;
			4'h2: y = 4'h6;
			4'h3: y = 4'hB;
			4'h4: y = 4'h9;
			4'h5: y = 4'h0;
			4'h6: y = 4'hA;
			4'h7: y = 4'hD;
			4'h8: y = 4'h3;
			4'h9: y = 4'hE;
			4'hA: y = 4'hF;
			4'hB: y = 4'h8;
			4'hC: y = 4'h4;
			4'hD: y = 4'h7;
			4'hE: y = 4'h1;
			4'hF: y = 4'h2;
			default: y = 4'h0;
		endcase
		return y;
	endfunction

	function automatic logic [63:0] sub_layer(input logic [63:0] s);
		logic [63:0] r;
		for (int n = 0; n < 16; n++) begin
			r[4*n +: 4] = sbox4(s[4*n +: 4]);
		end
		return r;
	endfunction

	// Bit i moves to 16*i mod 63; bit 63 stays in place.
	function automatic logic [63:0] perm_layer(input logic [63:0] s);
		logic [63:0] r;
		for (int i = 0; i < 63; i++) begin
			r[(i * 16) % 63] = s[i];
		end
		r[63] = s[63];
		return r;
	endfunction

	// 80-bit schedule: key_hi holds bits 79..16, key_lo[15:0] bits 15..0.
	function automatic logic [127:0] key80_step(input logic [63:0] h, input logic [15:0] l,
			input logic [4:0] rc);
		logic [63:0] nh;
		logic [15:0] nl;
		nh = {h[2:0], l, h[63:19]};
		nl = h[18:3];
		nh[63:60] = sbox4(nh[63:60]);
		nh[3:0] = nh[3:0] ^ rc[4:1];
		nl[15] = nl[15] ^ rc[0];
		return {nh, 48'd0, nl};
	endfunction

	// 128-bit schedule: key_hi holds bits 127..64, key_lo bits 63..0.
	function automatic logic [127:0] key128_step(input logic [63:0] h, input logic [63:0] l,
			input logic [4:0] rc);
		logic [63:0] nh;
		logic [63:0] nl;
		nh = {h[2:0], l[63:3]};
		nl = {l[2:0], h[63:3]};
		nh[63:60] = sbox4(nh[63:60]);
		nh[59:56] = sbox4(nh[59:56]);
		nh[2:0] = nh[2:0] ^ rc[4:2];
		nl[63:62] = nl[63:62] ^ rc[1:0];
		return {nh, nl};
	endfunction

endpackage

>>> hdl/pres_round.sv
// One registered PRESENT round: key mixing, S-box layer, permutation and key update.
module pres_round import pres_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  pres_stage_t in_stage,
	input  logic [4:0]  rc,
	output logic        out_valid,
	output pres_stage_t out_stage
);

	logic        valid_s1;
	pres_stage_t stage_s1;
	pres_stage_t next_stage;
	logic [127:0] key_next;

	always_comb begin
		next_stage.state = perm_layer(sub_layer(in_stage.state ^ in_stage.key_hi));
		if (in_stage.wide) begin
			key_next = key128_step(in_stage.key_hi, in_stage.key_lo, rc);
		end else begin
			key_next = key80_step(in_stage.key_hi, in_stage.key_lo[15:0], rc);
		end
		next_stage.key_hi = key_next[127:64];
		next_stage.key_lo = key_next[63:0];
		next_stage.wide   = in_stage.wide;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Payload flows every cycle; only the valid bit needs reset.
	always_ff @(posedge clk) begin
		stage_s1 <= next_stage;
	end

	assign out_valid = valid_s1;
	assign out_stage = stage_s1;

endmodule

>>> hdl/present_block_encrypt.sv
// Top level of the fully unrolled PRESENT block encryption pipeline.
//
// Usage: a 64-bit plaintext block is transferred on plain_block at a rising
// clock edge where start is high and busy is low. The block is encrypted with
// the master key and key size mode held in the configuration registers, and the
// ciphertext appears on cipher_block with done high for exactly one cycle.
// Configuration is written through cfg_valid/cfg_ready with a register index
// (0 = key size mode, 1 = upper key word, 2 = lower key word) and cfg_data;
// a write to index 3 is ignored. Registers are to be written by the user only
// while no block is in flight; the block itself does not enforce this.
// The accepting edge loads the entry register; the 31 round registers and the
// output register follow in order, and done is driven by the output register.
// Throughput is one block per clock, since each of the 31 rounds has its own
// register stage and the key schedule rides along with the data.
// Reset clears the configuration registers to zero and empties the pipeline;
// busy is set by reset, and its register clears once clocked after release.
// The receiver cannot stall, so the pipeline never holds and busy never
// throttles a running stream of blocks.
module present_block_encrypt import pres_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plain_block,
	output logic        done,
	output logic [63:0] cipher_block,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	// Configuration registers.
	logic        key_size_mode_q;
	logic [63:0] key_upper_q;
	logic [63:0] key_lower_q;

	// Busy is held high only while coming out of reset.
	logic        busy_q;

	// Entry stage: captures the block together with the master key state.
	logic        valid_s0;
	pres_stage_t stage_s0;

	// Chain of round stages; element 0 is the entry stage.
	logic        pipe_valid [0:NumRounds];
	pres_stage_t pipe_stage [0:NumRounds];

	// Output register after the final key whitening.
	logic        done_q;
	logic [63:0] cipher_q;

	logic        accept;

	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;

	// Configuration writes are transfers on their own channel; an unknown
	// index leaves every register unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_mode_q <= 1'b0;
			key_upper_q     <= 64'd0;
			key_lower_q     <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_KEY_SIZE_MODE: key_size_mode_q <= cfg_data[0];
				CFG_KEY_UPPER:     key_upper_q     <= cfg_data;
				CFG_KEY_LOWER:     key_lower_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s0 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s0 <= accept;
			done_q   <= pipe_valid[NumRounds];
		end
	end

	// In 80-bit mode only the low 16 bits of the lower key word take part,
	// so the rest is cleared before the schedule starts.
	always_ff @(posedge clk) begin
		stage_s0.state  <= plain_block;
		stage_s0.key_hi <= key_upper_q;
		stage_s0.key_lo <= key_size_mode_q ? key_lower_q : {48'd0, key_lower_q[15:0]};
		stage_s0.wide   <= key_size_mode_q;
		cipher_q        <= pipe_stage[NumRounds].state ^ pipe_stage[NumRounds].key_hi;
	end

	assign pipe_valid[0] = valid_s0;
	assign pipe_stage[0] = stage_s0;

	// Round g uses round counter g for its key update.
	for (genvar g = 1; g <= NumRounds; g++) begin : g_round
		pres_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (pipe_valid[g-1]),
			.in_stage  (pipe_stage[g-1]),
			.rc        (5'(g)),
			.out_valid (pipe_valid[g]),
			.out_stage (pipe_stage[g])
		);
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign cipher_block = cipher_q;

endmodule
